>>> hw/rtl/avd_pkg.sv
// Shared types, constants and the arctangent table for the airborne velocity decoder.
package avd_pkg;

  // Number of CORDIC micro-rotations; the table holds at most ATAN_LEN of them.
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int STAGE_W       = $clog2(ATAN_LEN);

  // Width of the rotation datapath (magnitudes stay below 2^30).
  localparam int CW = 32;

  // Velocity kinds on the result.
  localparam logic [1:0] KIND_GROUND   = 2'd0;
  localparam logic [1:0] KIND_AIR      = 2'd1;
  localparam logic [1:0] KIND_RESERVED = 2'd2;

  // Message subtypes.
  localparam logic [2:0] ST_GROUND_X1 = 3'd1;
  localparam logic [2:0] ST_GROUND_X4 = 3'd2;
  localparam logic [2:0] ST_AIR_X1    = 3'd3;
  localparam logic [2:0] ST_AIR_X4    = 3'd4;

  // CORDIC gain correction in Q30 and the half-turn binary angle.
  localparam logic [29:0] GAIN_Q30  = 30'd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Rounded arctangent of 2^-i, in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Decoded fields that ride alongside the rotation.
  typedef struct packed {
    logic [1:0]  kind;
    logic        spd_ok;
    logic [12:0] spd;
    logic        hdg_ok;
    logic [15:0] hdg;
    logic        clb_ok;
    logic [15:0] clb;
    logic        use_cordic;
    logic        north_neg;
    logic        east_neg;
  } side_t;

  // One request as it moves down the cell chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    side_t                side;
  } rot_t;

endpackage

>>> hw/rtl/avd_decode.sv
// Input stage: field extraction, vertical rate, airspeed and CORDIC start vector.
module avd_decode
  import avd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [55:0] message_field,
  output logic        in_ready,
  output logic        out_valid,
  output rot_t        out_data,
  input  logic        out_ready
);

  rot_t d_next;

  always_comb begin
    logic [2:0]  st;
    logic [8:0]  vr;
    logic [9:0]  f_hi;
    logic [9:0]  f_lo;
    logic [9:0]  hi_m1;
    logic [9:0]  lo_m1;
    logic [14:0] clb_mag;
    logic [11:0] emag;
    logic [11:0] nmag;
    logic        ground;
    logic        air;
    st      = message_field[50:48];
    vr      = message_field[18:10];
    f_hi    = message_field[41:32];
    f_lo    = message_field[30:21];
    hi_m1   = f_hi - 10'd1;
    lo_m1   = f_lo - 10'd1;
    clb_mag = {vr - 9'd1, 6'b0};
    ground  = (st == ST_GROUND_X1) || (st == ST_GROUND_X4);
    air     = (st == ST_AIR_X1) || (st == ST_AIR_X4);
    emag    = (st == ST_GROUND_X4) ? {hi_m1, 2'b0} : {2'b0, hi_m1};
    nmag    = (st == ST_GROUND_X4) ? {lo_m1, 2'b0} : {2'b0, lo_m1};

    d_next   = '0;
    d_next.x = {4'b0, nmag, 16'b0};
    d_next.y = {4'b0, emag, 16'b0};

    // vertical rate, decoded for every subtype
    if (vr != 9'd0) begin
      d_next.side.clb_ok = 1'b1;
      d_next.side.clb    = message_field[19] ? 16'd0 - {1'b0, clb_mag} : {1'b0, clb_mag};
    end

    d_next.side.kind = KIND_RESERVED;
    if (ground) begin
      d_next.side.kind = KIND_GROUND;
      if (f_hi != 10'd0 && f_lo != 10'd0) begin
        d_next.side.spd_ok     = 1'b1;
        d_next.side.use_cordic = (emag != 12'd0) || (nmag != 12'd0);
        d_next.side.hdg_ok     = d_next.side.use_cordic;
        d_next.side.north_neg  = message_field[31] && (nmag != 12'd0);
        d_next.side.east_neg   = message_field[42] && (emag != 12'd0);
      end
    end else if (air) begin
      d_next.side.kind = KIND_AIR;
      if (f_lo != 10'd0) begin
        d_next.side.spd_ok = 1'b1;
        d_next.side.spd    = (st == ST_AIR_X4) ? {1'b0, lo_m1, 2'b0} : {3'b0, lo_m1};
      end
      if (message_field[42]) begin
        d_next.side.hdg_ok = 1'b1;
        d_next.side.hdg    = {f_hi, 6'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  // hold the request until the first cell takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= d_next;
    end
  end

endmodule

>>> hw/rtl/avd_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its own pipeline register.
module avd_cordic_cell
  import avd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [STAGE_W-1:0] idx,
  input  logic               in_valid,
  input  rot_t               in_data,
  output logic               in_ready,
  output logic               out_valid,
  output rot_t               out_data,
  input  logic               out_ready
);

  rot_t r_next;

  // rotate towards the x axis, accumulating the angle
  always_comb begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    x  = in_data.x;
    y  = in_data.y;
    xs = x >>> idx;
    ys = y >>> idx;
    r_next = in_data;
    if (y > 0) begin
      r_next.x = x + ys;
      r_next.y = y - xs;
      r_next.z = in_data.z + ATAN_TURN[idx];
    end else begin
      r_next.x = x - ys;
      r_next.y = y + xs;
      r_next.z = in_data.z - ATAN_TURN[idx];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= r_next;
    end
  end

endmodule

>>> hw/rtl/avd_finish.sv
// Gain correction, quadrant fold, rounding and the output register.
module avd_finish
  import avd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  rot_t        in_data,
  output logic        in_ready,
  output logic        out_valid,
  output logic [1:0]  velocity_kind,
  output logic        speed_valid,
  output logic [12:0] speed_knots,
  output logic        heading_valid,
  output logic [15:0] heading_angle,
  output logic        climb_valid,
  output logic signed [15:0] climb_rate_fpm,
  input  logic        out_ready
);

  // multiply stage
  logic        mul_valid;
  logic        mul_ready;
  logic [60:0] prod;
  logic [15:0] cdc_hdg;
  side_t       mul_side;
  logic [60:0] prod_next;
  logic [15:0] cdc_hdg_next;
  logic [31:0] ang;
  logic [60:0] rounded;

  assign prod_next = {30'b0, in_data.x[30:0]} * {31'b0, GAIN_Q30};

  // fold the first-quadrant angle into the full turn
  always_comb begin
    unique case ({in_data.side.north_neg, in_data.side.east_neg})
      2'b00:   ang = in_data.z;
      2'b01:   ang = 32'd0 - in_data.z;
      2'b10:   ang = HALF_TURN - in_data.z;
      default: ang = HALF_TURN + in_data.z;
    endcase
    cdc_hdg_next = ang[31:16] + {15'b0, ang[15]};
  end

  assign in_ready  = !mul_valid || mul_ready;
  assign mul_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod     <= prod_next;
      cdc_hdg  <= cdc_hdg_next;
      mul_side <= in_data.side;
    end
  end

  // round the corrected magnitude to whole knots
  assign rounded = prod + (61'd1 <<< 45);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  // load the result register when it is empty or being taken
  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid) begin
      velocity_kind  <= mul_side.kind;
      speed_valid    <= mul_side.spd_ok;
      speed_knots    <= mul_side.use_cordic ? rounded[58:46] : mul_side.spd;
      heading_valid  <= mul_side.hdg_ok;
      heading_angle  <= mul_side.use_cordic ? cdc_hdg : mul_side.hdg;
      climb_valid    <= mul_side.clb_ok;
      climb_rate_fpm <= mul_side.clb;
    end
  end

endmodule

>>> hw/rtl/airborne_velocity_decoder.sv
// Airborne velocity decoder top level: decode stage, CORDIC cell chain, finish stage.
//
// Input channel: msg_valid / msg_stall with message_field, the 56-bit message
// field of an airborne velocity squitter. A request is taken at each clock edge
// where msg_valid is high and msg_stall is low.
// Output channel: vel_valid / vel_stall with the decoded kind, speed, heading
// and vertical rate, one result per request, in request order.
// Registers between acceptance and vel_valid, in order: the decode register,
// one register per CORDIC cell, one register after the gain multiplier and
// the output register.
// Throughput: one request per cycle unless stalled. Every stage has its own
// valid bit and takes a new request whenever it is empty or its successor
// is taking its contents, so bubbles close up while the output is stalled.
// When vel_stall is high the result holds steady; requests keep entering
// until every stage is full, after which msg_stall rises.
// Reset (rst, synchronous) empties every stage; no result is pending after it.
module airborne_velocity_decoder
  import avd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [55:0] message_field,
  output logic        vel_valid,
  input  logic        vel_stall,
  output logic [1:0]  velocity_kind,
  output logic        speed_valid,
  output logic [12:0] speed_knots,
  output logic        heading_valid,
  output logic [15:0] heading_angle,
  output logic        climb_valid,
  output logic signed [15:0] climb_rate_fpm
);

  logic chain_valid [CORDIC_RUN+1];
  logic chain_ready [CORDIC_RUN+1];
  rot_t chain_data  [CORDIC_RUN+1];
  logic dec_ready;

  assign msg_stall = !dec_ready;

  avd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (msg_valid),
    .message_field (message_field),
    .in_ready      (dec_ready),
    .out_valid     (chain_valid[0]),
    .out_data      (chain_data[0]),
    .out_ready     (chain_ready[0])
  );

  // chain of micro-rotation cells
  for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_cell
    avd_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (STAGE_W'(i)),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .in_ready  (chain_ready[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1]),
      .out_ready (chain_ready[i+1])
    );
  end

  avd_finish u_finish (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (chain_valid[CORDIC_RUN]),
    .in_data        (chain_data[CORDIC_RUN]),
    .in_ready       (chain_ready[CORDIC_RUN]),
    .out_valid      (vel_valid),
    .velocity_kind  (velocity_kind),
    .speed_valid    (speed_valid),
    .speed_knots    (speed_knots),
    .heading_valid  (heading_valid),
    .heading_angle  (heading_angle),
    .climb_valid    (climb_valid),
    .climb_rate_fpm (climb_rate_fpm),
    .out_ready      (!vel_stall)
  );

`ifndef SYNTHESIS
  // pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !vel_valid)
    else $error("result present right after reset");

  // reserved subtypes carry no speed or heading
  a_reserved_blank: assert property (@(posedge clk) disable iff (rst)
    vel_valid && velocity_kind == KIND_RESERVED |-> !speed_valid && !heading_valid)
    else $error("reserved subtype reports speed or heading");

  // unavailable speed reads as zero
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    vel_valid && !speed_valid |-> speed_knots == 13'd0)
    else $error("speed nonzero while not available");

  // unavailable vertical rate reads as zero
  a_climb_zero: assert property (@(posedge clk) disable iff (rst)
    vel_valid && !climb_valid |-> climb_rate_fpm == 16'sd0)
    else $error("vertical rate nonzero while not available");
`endif

endmodule

>>> test/airborne_velocity_decoder_test.sv
// Self-checking testbench for the airborne velocity decoder.
module airborne_velocity_decoder_test
  import avd_pkg::*;
();

  localparam int LATENCY     = CORDIC_STAGES + 3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_MSGS = 1200;
  localparam int REPORT_MAX  = 10;

  // Type code 19 (airborne velocity) in the top five bits.
  localparam logic [55:0] TC_VELOCITY = 56'h98_0000_0000_0000;

  // Subtypes with no defined meaning.
  localparam logic [2:0] ST_RESERVED_0 = 3'd0;
  localparam logic [2:0] ST_RESERVED_5 = 3'd5;
  localparam logic [2:0] ST_RESERVED_6 = 3'd6;
  localparam logic [2:0] ST_RESERVED_7 = 3'd7;

  // Arctangent of 2^-i in 2^-32 turn, rounded.
  localparam logic [31:0] ARCTAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };
  localparam longint unsigned GAIN_CORRECTION = 64'd652032874;

  typedef struct packed {
    logic [1:0]  kind;
    logic        spd_ok;
    logic [12:0] spd;
    logic        hdg_ok;
    logic [15:0] hdg;
    logic        clb_ok;
    logic [15:0] clb;
  } velocity_t;

  // Predict decoded velocities and match them against the block's results.
  class velocity_ledger;
    velocity_t expected_velocities[$];
    int        errors;
    int        checked;
    int        kind_count[3];
    int        with_heading;
    int        with_climb;

    // Rotate (north, east) onto the north axis; return magnitude and bearing.
    function void vector_to_polar(input longint north, input longint east,
                                  output longint unsigned mag,
                                  output logic [31:0] bearing);
      longint      x, y, z, xs, ys;
      logic [31:0] q;
      int          i;
      x = (north < 0 ? -north : north) * 65536;
      y = (east < 0 ? -east : east) * 65536;
      z = 0;
      for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_STEP[i];
        end
      end
      mag = (longint'(unsigned'(x)) * GAIN_CORRECTION + (64'd1 << 45)) >> 46;
      q = z[31:0];
      if (north >= 0) begin
        bearing = (east >= 0) ? q : 32'd0 - q;
      end else begin
        bearing = (east >= 0) ? 32'h8000_0000 - q : 32'h8000_0000 + q;
      end
    endfunction

    function velocity_t decode_velocity(input logic [55:0] me);
      velocity_t       r;
      logic [2:0]      st;
      logic [8:0]      vr;
      logic [9:0]      f_hi, f_lo;
      int              rate;
      longint          east, north, scale;
      longint unsigned mag;
      logic [31:0]     bearing;
      logic [32:0]     rounded;
      r = '0;
      r.kind = KIND_RESERVED;
      st = me[50:48];
      vr = me[18:10];
      f_hi = me[41:32];
      f_lo = me[30:21];
      // Vertical rate: raw zero means not available.
      if (vr != 0) begin
        rate = 64 * (int'(vr) - 1);
        if (me[19]) rate = -rate;
        r.clb_ok = 1'b1;
        r.clb = 16'(rate);
      end
      if (st == ST_GROUND_X1 || st == ST_GROUND_X4) begin
        scale = (st == ST_GROUND_X1) ? 1 : 4;
        r.kind = KIND_GROUND;
        if (f_hi != 0 && f_lo != 0) begin
          east = scale * (longint'(f_hi) - 1);
          north = scale * (longint'(f_lo) - 1);
          if (me[42]) east = -east;
          if (me[31]) north = -north;
          r.spd_ok = 1'b1;
          // A zero vector has a speed of zero but no heading.
          if (east != 0 || north != 0) begin
            vector_to_polar(north, east, mag, bearing);
            rounded = {1'b0, bearing} + 33'h8000;
            r.spd = 13'(mag);
            r.hdg_ok = 1'b1;
            r.hdg = rounded[31:16];
          end
        end
      end else if (st == ST_AIR_X1 || st == ST_AIR_X4) begin
        scale = (st == ST_AIR_X1) ? 1 : 4;
        r.kind = KIND_AIR;
        if (f_lo != 0) begin
          r.spd_ok = 1'b1;
          r.spd = 13'(scale * (longint'(f_lo) - 1));
        end
        // Heading status bit gates the magnetic heading.
        if (me[42]) begin
          r.hdg_ok = 1'b1;
          r.hdg = {f_hi, 6'd0};
        end
      end
      return r;
    endfunction

    function void note_message(input logic [55:0] me);
      velocity_t v;
      v = decode_velocity(me);
      expected_velocities.push_back(v);
      kind_count[v.kind]++;
      if (v.hdg_ok) with_heading++;
      if (v.clb_ok) with_climb++;
    endfunction

    function void check_velocity(input velocity_t got);
      velocity_t want;
      if (expected_velocities.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected velocity result: kind %0d spd %0d/%0d hdg %0d/%0d clb %0d/%0d",
                   got.kind, got.spd_ok, got.spd, got.hdg_ok, got.hdg, got.clb_ok,
                   $signed(got.clb));
        return;
      end
      want = expected_velocities.pop_front();
      checked++;
      if (got.kind !== want.kind || got.spd_ok !== want.spd_ok || got.spd !== want.spd ||
          got.hdg_ok !== want.hdg_ok || got.hdg !== want.hdg ||
          got.clb_ok !== want.clb_ok || got.clb !== want.clb) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("result %0d differs: expected kind %0d spd %0d/%0d hdg %0d/%0d clb %0d/%0d",
                   checked, want.kind, want.spd_ok, want.spd, want.hdg_ok, want.hdg,
                   want.clb_ok, $signed(want.clb));
          $display("                      got kind %0d spd %0d/%0d hdg %0d/%0d clb %0d/%0d",
                   got.kind, got.spd_ok, got.spd, got.hdg_ok, got.hdg, got.clb_ok,
                   $signed(got.clb));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [55:0] message_field = '0;
  logic        vel_valid;
  logic        vel_stall = 1'b0;
  logic [1:0]  velocity_kind;
  logic        speed_valid;
  logic [12:0] speed_knots;
  logic        heading_valid;
  logic [15:0] heading_angle;
  logic        climb_valid;
  logic signed [15:0] climb_rate_fpm;

  velocity_ledger ledger = new();
  velocity_t      seen;
  bit             idle_on = 1'b0;
  int             stall_left = 0;
  int             cycles = 0;

  airborne_velocity_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_stall      (msg_stall),
    .message_field  (message_field),
    .vel_valid      (vel_valid),
    .vel_stall      (vel_stall),
    .velocity_kind  (velocity_kind),
    .speed_valid    (speed_valid),
    .speed_knots    (speed_knots),
    .heading_valid  (heading_valid),
    .heading_angle  (heading_angle),
    .climb_valid    (climb_valid),
    .climb_rate_fpm (climb_rate_fpm)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycles,
               ledger.expected_velocities.size());
      $display("airborne_velocity_decoder: mismatch");
      $finish;
    end
  end

  // Take results and stall the output in random bursts.
  always @(posedge clk) begin
    if (!rst && vel_valid && !vel_stall) begin
      seen.kind = velocity_kind;
      seen.spd_ok = speed_valid;
      seen.spd = speed_knots;
      seen.hdg_ok = heading_valid;
      seen.hdg = heading_angle;
      seen.clb_ok = climb_valid;
      seen.clb = climb_rate_fpm;
      ledger.check_velocity(seen);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      vel_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      vel_stall <= 1'b1;
    end else begin
      vel_stall <= 1'b0;
    end
  end

  function automatic logic [55:0] make_message(input logic [55:0] base, input logic [2:0] st,
                                               input logic ew_neg, input logic [9:0] ew,
                                               input logic ns_neg, input logic [9:0] ns,
                                               input logic vr_neg, input logic [8:0] vr);
    logic [55:0] m;
    m = base;
    m[50:48] = st;
    m[42] = ew_neg;
    m[41:32] = ew;
    m[31] = ns_neg;
    m[30:21] = ns;
    m[19] = vr_neg;
    m[18:10] = vr;
    return m;
  endfunction

  // Bias raw values towards zero, one and full scale.
  function automatic logic [9:0] pick_raw(input logic [9:0] top);
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return '0;
    if (c == 1) return 10'd1;
    if (c == 2) return top;
    return 10'($urandom) & top;
  endfunction

  function automatic logic [2:0] pick_subtype();
    int c;
    c = $urandom_range(0, 19);
    if (c < 17) return 3'($urandom_range(1, 4));
    case ($urandom_range(0, 3))
      0: return ST_RESERVED_0;
      1: return ST_RESERVED_5;
      2: return ST_RESERVED_6;
      default: return ST_RESERVED_7;
    endcase
  endfunction

  // Present one request, with an optional random gap ahead of it.
  task automatic send_message(input logic [55:0] msg);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    message_field <= msg;
    do @(posedge clk); while (msg_stall);
    ledger.note_message(msg);
  endtask

  initial begin
    logic [55:0] base;
    logic [9:0]  vr_raw;
    int          k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every subtype, zero raw values and axis headings.
    send_message('0);
    send_message({56{1'b1}});
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'd2, 1'b0, 10'd1,
                              1'b0, 9'd1));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'd1, 1'b0, 10'd1,
                              1'b0, 9'd5));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'd0, 1'b0, 10'd40,
                              1'b1, 9'd9));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b1, 10'd40, 1'b0, 10'd0,
                              1'b0, 9'd0));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'h3FF, 1'b0, 10'h3FF,
                              1'b0, 9'h1FF));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X4, 1'b1, 10'h3FF, 1'b1, 10'h3FF,
                              1'b1, 9'h1FF));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X4, 1'b1, 10'h3FF, 1'b0, 10'h3FF,
                              1'b0, 9'd2));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X4, 1'b0, 10'h3FF, 1'b1, 10'h3FF,
                              1'b1, 9'd2));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'd1, 1'b1, 10'd500,
                              1'b0, 9'd3));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b1, 10'd300, 1'b0, 10'd1,
                              1'b0, 9'd3));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X1, 1'b0, 10'd2, 1'b0, 10'd2,
                              1'b0, 9'd3));
    send_message(make_message(TC_VELOCITY, ST_GROUND_X4, 1'b1, 10'd1, 1'b1, 10'd1,
                              1'b1, 9'd4));
    send_message(make_message(TC_VELOCITY, ST_AIR_X1, 1'b1, 10'h3FF, 1'b0, 10'd0,
                              1'b0, 9'd7));
    send_message(make_message(TC_VELOCITY, ST_AIR_X1, 1'b0, 10'd100, 1'b1, 10'h3FF,
                              1'b1, 9'd7));
    send_message(make_message(TC_VELOCITY, ST_AIR_X4, 1'b1, 10'd0, 1'b0, 10'h3FF,
                              1'b0, 9'd8));
    send_message(make_message(TC_VELOCITY, ST_AIR_X4, 1'b1, 10'd512, 1'b0, 10'd2,
                              1'b0, 9'd8));
    send_message(make_message(TC_VELOCITY, ST_RESERVED_5, 1'b1, 10'd9, 1'b1, 10'd9,
                              1'b1, 9'd1));
    send_message(make_message(TC_VELOCITY, ST_RESERVED_6, 1'b0, 10'd9, 1'b0, 10'd9,
                              1'b0, 9'h1FF));
    send_message(make_message(TC_VELOCITY, ST_RESERVED_0, 1'b1, 10'h3FF, 1'b1, 10'h3FF,
                              1'b0, 9'd6));
    send_message(make_message(TC_VELOCITY, ST_RESERVED_7, 1'b0, 10'd3, 1'b0, 10'd3,
                              1'b1, 9'd2));

    // Random: well-formed velocity fields over random filler bits.
    for (k = 0; k < RANDOM_MSGS; k++) begin
      // Alternate idling and full-rate stretches; finish at full rate.
      idle_on = (k < RANDOM_MSGS - 200) && ((k / 150) % 2 == 0);
      base = {24'($urandom), 32'($urandom)};
      vr_raw = pick_raw(10'h1FF);
      send_message(make_message(base, pick_subtype(), 1'($urandom), pick_raw(10'h3FF),
                                1'($urandom), pick_raw(10'h3FF), 1'($urandom),
                                vr_raw[8:0]));
    end
    idle_on = 1'b0;
    msg_valid <= 1'b0;

    // Drain the pipeline, then allow for any stray output.
    while (ledger.expected_velocities.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("decoded %0d velocity reports: %0d ground, %0d airspeed, %0d reserved subtype",
             ledger.checked, ledger.kind_count[KIND_GROUND], ledger.kind_count[KIND_AIR],
             ledger.kind_count[KIND_RESERVED]);
    $display("%0d carried a heading, %0d a vertical rate; %0d discrepancies",
             ledger.with_heading, ledger.with_climb, ledger.errors);
    if (ledger.errors == 0 && ledger.expected_velocities.size() == 0) begin
      $display("airborne_velocity_decoder: match");
    end else begin
      $display("airborne_velocity_decoder: mismatch");
    end
    $finish;
  end

endmodule
